// File: src/srd_pkg.sv
// Shared types and constants for the segmented record deframer.
package srd_pkg;

  localparam int unsigned SegLenW  = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [SegLenW-1:0] SegLenReset  = 12'd2042;
  localparam logic [ByteW-1:0]   NewlineByte  = 8'h0A;
  localparam logic [ByteW-1:0]   LabelTypeMax = 8'd3;

  // Word index of each configuration register (byte address / 4)
  localparam logic [ApbAddrW-3:0] RegSegLen = 1'b0;

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhLabel  = 2'd1,
    PhFixed  = 2'd2,
    PhVaried = 2'd3
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StLabelValue = 3'd1,
    StBadType    = 3'd2,
    StOverrun    = 3'd3,
    StEarlyEnd   = 3'd4,
    StHalted     = 3'd5
  } status_e;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdEnd  = 1'b1
  } cmd_e;

endpackage

// File: src/srd_if.sv
// Valid/ready channel interfaces for the input requests and the result items.
interface srd_in_if;
  import srd_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [ByteW-1:0] stream_byte;

  modport source (output valid, output command, output stream_byte, input ready);
  modport sink   (input valid, input command, input stream_byte, output ready);
endinterface

interface srd_out_if;
  import srd_pkg::*;
  logic               valid;
  logic               ready;
  logic               payload_valid;
  logic [ByteW-1:0]   payload_byte;
  logic [StatusW-1:0] status;

  modport source (output valid, output payload_valid, output payload_byte, output status,
                  input ready);
  modport sink   (input valid, input payload_valid, input payload_byte, input status,
                  output ready);
endinterface

// File: src/srd_cfg_regs.sv
// APB configuration register block: holds segment_length.
module srd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [srd_pkg::ApbDataW-1:0]   pwdata,
  output logic [srd_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output logic [srd_pkg::SegLenW-1:0]    seg_len_o
);
  import srd_pkg::*;

  logic [SegLenW-1:0]    seg_len_q;
  logic [ApbAddrW-3:0]   word_idx;
  logic                  wr_en;

  assign pready   = 1'b1;
  assign word_idx = paddr[ApbAddrW-1:2];
  assign wr_en    = psel && penable && pwrite && pready;

  // Register write; writes to unmapped words are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q <= SegLenReset;
    end else if (wr_en && (word_idx == RegSegLen)) begin
      seg_len_q <= pwdata[SegLenW-1:0];
    end
  end

  // Read mux
  always_comb begin
    unique case (word_idx)
      RegSegLen: prdata = {{(ApbDataW-SegLenW){1'b0}}, seg_len_q};
      default:   prdata = '0;
    endcase
  end

  assign seg_len_o = seg_len_q;

endmodule

// File: src/srd_engine.sv
// Deframing engine: input register, label/segment state update, result register.
module srd_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srd_pkg::SegLenW-1:0] seg_len_i,
  srd_in_if.sink                      in_i,
  srd_out_if.source                   out_o
);
  import srd_pkg::*;

  // Input stage
  logic             in_valid_q;
  cmd_e             cmd_q;
  logic [ByteW-1:0] byte_q;

  // Framing state
  phase_e             phase_q, phase_d;
  logic               varied_q, varied_d;
  logic [SegLenW-1:0] left_q, left_d;
  logic               nl_q, nl_d;
  logic               halted_q, halted_d;

  // Result stage
  logic             out_valid_q;
  logic             pv_q;
  logic [ByteW-1:0] pb_q;
  status_e          st_q;

  logic             advance;
  logic             in_acc;
  phase_e           eff_phase;
  logic             eff_nl;
  logic             res_valid;
  logic [ByteW-1:0] res_byte;
  status_e          res_status;

  // Handshake: the input stage moves on when the result slot is free or drains
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_e'(in_i.command);
      byte_q <= in_i.stream_byte;
    end
  end

  // A used-up fixed segment behaves as start phase with a newline allowed
  always_comb begin
    if (phase_q == PhFixed && left_q == '0) begin
      eff_phase = PhStart;
      eff_nl    = 1'b1;
    end else begin
      eff_phase = phase_q;
      eff_nl    = nl_q;
    end
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    varied_d = varied_q;
    left_d   = left_q;
    nl_d     = nl_q;
    halted_d = halted_q;
    if (!halted_q) begin
      if (cmd_q == CmdEnd) begin
        if ((phase_q == PhFixed && left_q != '0) || phase_q == PhLabel) begin
          halted_d = 1'b1;
        end else begin
          phase_d = PhStart;
          nl_d    = 1'b1;
        end
      end else begin
        phase_d = eff_phase;
        nl_d    = eff_nl;
        unique case (eff_phase)
          PhStart: begin
            nl_d = 1'b0;
            if (!(eff_nl && byte_q == NewlineByte)) begin
              if (byte_q > LabelTypeMax) begin
                halted_d = 1'b1;
              end else begin
                varied_d = byte_q[1];
                left_d   = seg_len_i;
                phase_d  = PhLabel;
              end
            end
          end
          PhLabel: begin
            if (byte_q != '0) begin
              halted_d = 1'b1;
            end else begin
              phase_d = varied_q ? PhVaried : PhFixed;
            end
          end
          default: begin
            if (left_q == '0) begin
              halted_d = 1'b1;
            end else begin
              left_d = left_q - 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Result for the item in the input stage
  always_comb begin
    res_valid  = 1'b0;
    res_byte   = '0;
    res_status = StOk;
    if (halted_q) begin
      res_status = StHalted;
    end else if (cmd_q == CmdEnd) begin
      if ((phase_q == PhFixed && left_q != '0) || phase_q == PhLabel) begin
        res_status = StEarlyEnd;
      end
    end else begin
      unique case (eff_phase)
        PhStart: begin
          if (!(eff_nl && byte_q == NewlineByte) && byte_q > LabelTypeMax) begin
            res_status = StBadType;
          end
        end
        PhLabel: begin
          if (byte_q != '0) begin
            res_status = StLabelValue;
          end
        end
        default: begin
          if (left_q == '0) begin
            res_status = StOverrun;
          end else begin
            res_valid = 1'b1;
            res_byte  = byte_q;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      varied_q <= 1'b0;
      left_q   <= '0;
      nl_q     <= 1'b0;
      halted_q <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      varied_q <= varied_d;
      left_q   <= left_d;
      nl_q     <= nl_d;
      halted_q <= halted_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pv_q <= res_valid;
      pb_q <= res_byte;
      st_q <= res_status;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_valid = pv_q;
  assign out_o.payload_byte  = pb_q;
  assign out_o.status        = st_q;

  // Once halted, the block stays halted until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  // Any error result sends the block into the halted state
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_status != StOk) |=> halted_q)
    else $error("error result without halt");

  // Payload bytes only come with an ok status
  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pv_q) |-> (st_q == StOk))
    else $error("payload byte with error status");

  // An empty input stage always takes a request
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input stage empty but not ready");

endmodule

// File: src/segmented_record_deframer.sv
// Top level of the segmented record deframer.
//
// Strips two-byte segment labels from a stream of record bytes. Each request
// is either one stream byte or an end-of-record command and yields exactly one
// result (payload byte flag, byte, status). The block takes one request per
// clock unless a full result register is not taken; each one passes through
// the input register and then the result register, with the framing state
// update computed between them. Results can back up one deep while the
// next request is already taken. After any error status the block answers
// every request with the halted status until reset. segment_length is written
// through the APB port at byte address 0 and must only change while idle.
module segmented_record_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [srd_pkg::ApbDataW-1:0]  pwdata,
  output logic [srd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  srd_in_if.sink                        in_i,
  srd_out_if.source                     out_o
);
  import srd_pkg::*;

  logic [SegLenW-1:0] seg_len;

  // Configuration registers
  srd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .seg_len_o (seg_len)
  );

  // Deframing datapath
  srd_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seg_len_i (seg_len),
    .in_i      (in_i),
    .out_o     (out_o)
  );

endmodule

// File: tb/tb_segmented_record_deframer.sv
// Testbench for the segmented record deframer: record streams checked by a scoreboard.
module tb_segmented_record_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 400;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned TailCycles = 8;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    status_e          status;
  } deframe_result_t;

  typedef enum int unsigned {
    ReadyAlways,
    ReadyMostly,
    ReadyAlternate,
    ReadyRarely
  } sink_mode_e;

  typedef enum int unsigned {
    FaultBadType,
    FaultLabelValue,
    FaultOverrun,
    FaultFixedEnd,
    FaultLabelEnd
  } fault_e;

  // Shadow of the framing state plus the queue of results still to come
  class deframe_scoreboard;
    logic [SegLenW-1:0] seg_len;
    phase_e             phase;
    logic               pend_varied;
    logic [SegLenW-1:0] left;
    logic               nl_ok;
    logic               halted;
    deframe_result_t    awaited[$];
    int unsigned        mismatches;

    function new();
      seg_len     = SegLenReset;
      phase       = PhStart;
      pend_varied = 1'b0;
      left        = '0;
      nl_ok       = 1'b0;
      halted      = 1'b0;
      mismatches  = 0;
    endfunction

    // One request through the label stripper: updates state, returns the result
    function deframe_result_t strip_label(cmd_e cmd, logic [ByteW-1:0] b);
      deframe_result_t r;
      r = '{payload_valid: 1'b0, payload_byte: '0, status: StOk};
      if (halted) begin
        r.status = StHalted;
        return r;
      end
      if (cmd == CmdEnd) begin
        // end is early inside a fixed segment with bytes left or mid-label
        if ((phase == PhFixed && left != 0) || phase == PhLabel) begin
          halted   = 1'b1;
          r.status = StEarlyEnd;
          return r;
        end
        phase = PhStart;
        nl_ok = 1'b1;
        return r;
      end
      // exhausted fixed segment: this byte begins the next label
      if (phase == PhFixed && left == 0) begin
        phase = PhStart;
        nl_ok = 1'b1;
      end
      case (phase)
        PhStart: begin
          if (nl_ok && b == NewlineByte) begin
            nl_ok = 1'b0;
          end else begin
            nl_ok = 1'b0;
            if (b > LabelTypeMax) begin
              halted   = 1'b1;
              r.status = StBadType;
            end else begin
              pend_varied = (b >= 8'd2);
              left        = seg_len;
              phase       = PhLabel;
            end
          end
        end
        PhLabel: begin
          if (b != 0) begin
            halted   = 1'b1;
            r.status = StLabelValue;
          end else begin
            phase = pend_varied ? PhVaried : PhFixed;
          end
        end
        default: begin
          if (left == 0) begin
            halted   = 1'b1;
            r.status = StOverrun;
          end else begin
            left            = left - 1'b1;
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(cmd_e cmd, logic [ByteW-1:0] b);
      awaited.push_back(strip_label(cmd, b));
    endfunction

    task report_mismatch(string msg);
      $display("%0t MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic pv, logic [ByteW-1:0] pb, logic [StatusW-1:0] st);
      deframe_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result pv=%0b byte=%02h status=%0d", pv, pb, st));
        return;
      end
      want = awaited.pop_front();
      if (pv !== want.payload_valid)
        report_mismatch($sformatf("payload_valid %0b, want %0b", pv, want.payload_valid));
      if (pb !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, want %02h", pb, want.payload_byte));
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
    endtask
  endclass

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  srd_in_if  in_if ();
  srd_out_if out_if ();

  deframe_scoreboard sb = new();

  int unsigned burst_left   = 0;
  int unsigned sent_items   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  logic        gen_nl_ok    = 1'b0;

  segmented_record_deframer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Monitor both channels and keep the no-progress watchdog
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_request(cmd_e'(in_if.command), in_if.stream_byte);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.payload_valid, out_if.payload_byte, out_if.status);
        results_seen <= results_seen + 1;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result sink: ready pattern changes per window, one long hold-off
  initial begin : result_sink
    sink_mode_e mode;
    bit         held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(16, 96)) begin
        @(posedge clk_i);
        if (!held && results_seen >= HoldAfter && in_if.valid) begin
          // block fills up and must back-pressure the sender
          held = 1'b1;
          out_if.ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          ReadyAlways:    out_if.ready <= 1'b1;
          ReadyMostly:    out_if.ready <= ($urandom_range(0, 3) != 0);
          ReadyAlternate: out_if.ready <= ~out_if.ready;
          default:        out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request; sender runs in bursts with random gaps between them
  task automatic feed_item(cmd_e cmd, logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.stream_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    sent_items++;
  endtask

  task automatic feed_end();
    feed_item(CmdEnd, 8'($urandom));
    gen_nl_ok = 1'b1;
  endtask

  task automatic feed_newline();
    feed_item(CmdByte, NewlineByte);
    gen_nl_ok = 1'b0;
  endtask

  task automatic maybe_newline();
    if (gen_nl_ok && $urandom_range(0, 2) == 0) feed_newline();
  endtask

  task automatic feed_label(logic [ByteW-1:0] kind);
    feed_item(CmdByte, kind);
    feed_item(CmdByte, 8'h00);
    gen_nl_ok = 1'b0;
  endtask

  // Fixed segment: label plus exactly len payload bytes
  task automatic feed_fixed_segment(int unsigned len);
    maybe_newline();
    feed_label(8'($urandom_range(0, 1)));
    repeat (len) feed_item(CmdByte, 8'($urandom));
    gen_nl_ok = 1'b1;
  endtask

  // Varied segment closed by an end command
  task automatic feed_varied_segment(int unsigned count);
    maybe_newline();
    feed_label(8'($urandom_range(2, 3)));
    repeat (count) feed_item(CmdByte, 8'($urandom));
    feed_end();
  endtask

  // Well-formed record: some fixed segments, then a varied tail, an end or nothing
  task automatic feed_record(int unsigned len);
    int unsigned nfix;
    int unsigned pick;
    int unsigned cap;
    nfix = (len <= 48) ? $urandom_range(0, 3) : 0;
    repeat (nfix) feed_fixed_segment(len);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      cap = ($urandom_range(0, 9) == 0) ? 200 : 24;
      if (cap > len) cap = len;
      if (len <= 64 && $urandom_range(0, 7) == 0) feed_varied_segment(len);
      else feed_varied_segment($urandom_range(0, cap));
    end else if (pick < 8 || nfix == 0) begin
      feed_end();
    end
    if ($urandom_range(0, 9) == 0) feed_end();
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // APB write of segment_length while the block is idle
  task automatic set_segment_length(logic [SegLenW-1:0] len);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegSegLen, 2'b00};
    pwdata  <= ApbDataW'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.seg_len = len;
  endtask

  initial begin : stimulus
    logic [SegLenW-1:0] len;
    int unsigned        phase_start;
    fault_e             fault;
    in_if.valid       <= 1'b0;
    in_if.command     <= CmdByte;
    in_if.stream_byte <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length: varied record carrying the byte extremes and a newline
    feed_label(8'd2);
    feed_item(CmdByte, 8'h00);
    feed_item(CmdByte, 8'hFF);
    feed_item(CmdByte, NewlineByte);
    feed_end();
    // End in start phase; the newline it allows is dropped
    feed_end();
    feed_newline();
    feed_label(8'd3);
    feed_item(CmdByte, 8'h55);
    feed_item(CmdByte, 8'hAA);
    feed_end();

    // Length 1: fixed segment runs out, newline dropped, end with nothing left
    set_segment_length(12'd1);
    feed_label(8'd1);
    feed_item(CmdByte, 8'h80);
    gen_nl_ok = 1'b1;
    feed_newline();
    feed_label(8'd0);
    feed_item(CmdByte, 8'h01);
    feed_end();
    // Varied segment filled to the limit, then closed
    feed_label(8'd2);
    feed_item(CmdByte, 8'h7F);
    feed_end();

    // Random records under several lengths, zero and full-scale among them
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       len = 12'd0;
        1:       len = 12'd4095;
        5:       len = SegLenW'($urandom_range(13, 4094));
        default: len = SegLenW'($urandom_range(1, 12));
      endcase
      set_segment_length(len);
      phase_start = sent_items;
      while (sent_items - phase_start < PhaseItems) feed_record(len);
    end

    // Last phase ends in one randomly chosen error, which halts the block
    len = SegLenW'($urandom_range(0, 6));
    set_segment_length(len);
    repeat (3) feed_record(len);
    fault = fault_e'($urandom_range(0, 4));
    if (fault == FaultFixedEnd && len == 0) fault = FaultLabelEnd;
    maybe_newline();
    case (fault)
      FaultBadType: begin
        if (gen_nl_ok) feed_newline();
        feed_item(CmdByte, 8'($urandom_range(4, 255)));
      end
      FaultLabelValue: begin
        feed_item(CmdByte, 8'($urandom_range(0, 3)));
        feed_item(CmdByte, 8'($urandom_range(1, 255)));
      end
      FaultOverrun: begin
        feed_label(8'($urandom_range(2, 3)));
        repeat (len + 1) feed_item(CmdByte, 8'($urandom));
      end
      FaultFixedEnd: begin
        feed_label(8'($urandom_range(0, 1)));
        repeat ($urandom_range(0, len - 1)) feed_item(CmdByte, 8'($urandom));
        feed_end();
      end
      default: begin
        feed_item(CmdByte, 8'($urandom_range(0, 3)));
        feed_end();
      end
    endcase
    // Halted: any request gets the halted status
    repeat (8) feed_item(cmd_e'($urandom_range(0, 1)), 8'($urandom));

    drain();
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
